@@ rtl/aptb_pkg.sv @@
// ============================================================================
// aptb_pkg: shared types and constants for the alpha premultiply block
// Register indexes, fixed field widths, the pixel mode bundle and the exact
// divide-by-255 helper used by the pixel datapath.
// ============================================================================
package aptb_pkg;

   // Widths fixed by the register map and the result fields.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int CFG_DIM_W   = 13;
   localparam int BOX_POS_W   = 12;
   localparam int BOX_SIZE_W  = 13;
   localparam int PIXEL_W     = 32;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREMULTIPLY   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIM          = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEXED_MODE  = 3'd4;

   // Pixel format controls handed to the pixel datapath.
   typedef struct packed {
      logic premultiply_on;
      logic indexed_mode;
   } mode_type;

   // Exact floor(p / 255) for any product of two bytes.
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] s;
      s = 17'(p) + 17'(p[15:8]) + 17'd1;
      return s[15:8];
   endfunction

endpackage

@@ rtl/alpha_premultiply_trim_bounds.sv @@
// ============================================================================
// alpha_premultiply_trim_bounds: premultiplied pixel stream with trim box
// Converts one raster-order pixel per beat and tracks the bounding box of
// visible pixels; the result beat of the frame's last pixel carries the box.
// ============================================================================
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_pixel_in
//   rsp_      out        rsp_valid/rsp_stall  pixel, frame_done, box fields
//   csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One pixel is taken every cycle unless req_stall is high; a pixel passes the
// input register and the result register around the pixel datapath.
// Reset is synchronous and restores the registers to a 1x1 frame with all
// modes off and the position counters at zero.
// A stalled result holds; the input register still takes one more beat,
// and req_stall rises only when both registers are full.
//
module alpha_premultiply_trim_bounds
   import aptb_pkg::*;
#(
   parameter int MAX_DIMENSION = 4096
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Pixel input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_pixel_in,
   // Result output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_W-1:0]     rsp_pixel_out,
   output logic                   rsp_frame_done,
   output logic [BOX_POS_W-1:0]   rsp_box_left,
   output logic [BOX_POS_W-1:0]   rsp_box_top,
   output logic [BOX_SIZE_W-1:0]  rsp_box_width,
   output logic [BOX_SIZE_W-1:0]  rsp_box_height,
   output logic                   rsp_all_transparent,
   // Register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_DIMENSION);
   localparam int SPAN_W = CNT_W + 1;
   localparam int CMP_W  = (SPAN_W > CFG_DIM_W) ? SPAN_W : CFG_DIM_W;

   // Configuration registers.
   logic [CFG_DIM_W-1:0] frame_width_ff, frame_height_ff;
   logic                 premul_on_ff, trim_on_ff, indexed_ff;

   // Input register and result register.
   logic                  s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0]    s1_pixel_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]    rsp_pixel_ff;
   logic                  rsp_done_ff, rsp_done_in;
   logic [BOX_POS_W-1:0]  rsp_left_ff, rsp_left_in;
   logic [BOX_POS_W-1:0]  rsp_top_ff, rsp_top_in;
   logic [BOX_SIZE_W-1:0] rsp_width_ff, rsp_width_in;
   logic [BOX_SIZE_W-1:0] rsp_height_ff, rsp_height_in;
   logic                  rsp_transp_ff, rsp_transp_in;

   // Position counters and box state.
   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [CNT_W-1:0] min_col_ff, min_col_in, max_col_ff, max_col_in;
   logic [CNT_W-1:0] min_row_ff, min_row_in, max_row_ff, max_row_in;
   logic             seen_ff, seen_in;

   logic [CNT_W-1:0] col_upd, row_upd;
   logic [CNT_W-1:0] min_col_upd, max_col_upd, min_row_upd, max_row_upd;
   logic             seen_box, seen_upd;

   logic               rsp_free, s1_fire, req_fire, csr_fire;
   logic [PIXEL_W-1:0] pixel_result;
   logic               visible, hit;
   logic [CMP_W-1:0]   fw_cmp, fh_cmp, w_lim, h_lim;
   logic               x_end, y_end, last;
   mode_type           mode;

   // Handshakes: the result register frees when empty or being taken.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && rsp_free;
   assign req_stall = s1_valid_ff && !rsp_free;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = rsp_free ? s1_valid_ff : rsp_valid_ff;

   // Pixel datapath.
   assign mode.premultiply_on = premul_on_ff;
   assign mode.indexed_mode   = indexed_ff;

   aptb_pixel u_pixel (
      .pixel        (s1_pixel_ff),
      .mode         (mode),
      .pixel_result (pixel_result),
      .visible      (visible)
   );

   // Frame size limited to 1..MAX_DIMENSION.
   assign fw_cmp = CMP_W'(frame_width_ff);
   assign fh_cmp = CMP_W'(frame_height_ff);
   assign w_lim  = (fw_cmp == '0) ? CMP_W'(1) :
                   (fw_cmp > CMP_W'(MAX_DIMENSION)) ? CMP_W'(MAX_DIMENSION) : fw_cmp;
   assign h_lim  = (fh_cmp == '0) ? CMP_W'(1) :
                   (fh_cmp > CMP_W'(MAX_DIMENSION)) ? CMP_W'(MAX_DIMENSION) : fh_cmp;

   assign x_end = CMP_W'(col_ff) >= (w_lim - CMP_W'(1));
   assign y_end = CMP_W'(row_ff) >= (h_lim - CMP_W'(1));
   assign last  = x_end && y_end;
   assign hit   = trim_on_ff && visible;

   // Box update for the current pixel.
   always_comb begin
      min_col_upd = min_col_ff;
      max_col_upd = max_col_ff;
      min_row_upd = min_row_ff;
      max_row_upd = max_row_ff;
      if (hit) begin
         if (!seen_ff) begin
            min_col_upd = col_ff;
            max_col_upd = col_ff;
            min_row_upd = row_ff;
            max_row_upd = row_ff;
         end else begin
            if (col_ff < min_col_ff) min_col_upd = col_ff;
            if (col_ff > max_col_ff) max_col_upd = col_ff;
            if (row_ff < min_row_ff) min_row_upd = row_ff;
            if (row_ff > max_row_ff) max_row_upd = row_ff;
         end
      end
      seen_box = seen_ff || hit;
   end

   // Result fields; the box is reported only on the last pixel.
   always_comb begin
      rsp_done_in   = last;
      rsp_left_in   = '0;
      rsp_top_in    = '0;
      rsp_width_in  = '0;
      rsp_height_in = '0;
      rsp_transp_in = 1'b0;
      if (last) begin
         if (trim_on_ff && seen_box) begin
            rsp_left_in   = BOX_POS_W'(min_col_upd);
            rsp_top_in    = BOX_POS_W'(min_row_upd);
            rsp_width_in  = BOX_SIZE_W'(SPAN_W'(max_col_upd) - SPAN_W'(min_col_upd)
                                        + SPAN_W'(1));
            rsp_height_in = BOX_SIZE_W'(SPAN_W'(max_row_upd) - SPAN_W'(min_row_upd)
                                        + SPAN_W'(1));
         end else begin
            rsp_width_in  = BOX_SIZE_W'(w_lim);
            rsp_height_in = BOX_SIZE_W'(h_lim);
            rsp_transp_in = trim_on_ff;
         end
      end
   end

   // Raster position advance.
   always_comb begin
      col_upd  = col_ff + CNT_W'(1);
      row_upd  = row_ff;
      seen_upd = seen_box;
      if (last) begin
         col_upd  = '0;
         row_upd  = '0;
         seen_upd = 1'b0;
      end else if (x_end) begin
         col_upd = '0;
         row_upd = row_ff + CNT_W'(1);
      end
   end

   assign col_in     = s1_fire ? col_upd : col_ff;
   assign row_in     = s1_fire ? row_upd : row_ff;
   assign seen_in    = s1_fire ? seen_upd : seen_ff;
   assign min_col_in = s1_fire ? min_col_upd : min_col_ff;
   assign max_col_in = s1_fire ? max_col_upd : max_col_ff;
   assign min_row_in = s1_fire ? min_row_upd : min_row_ff;
   assign max_row_in = s1_fire ? max_row_upd : max_row_ff;

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         col_ff          <= '0;
         row_ff          <= '0;
         min_col_ff      <= '0;
         max_col_ff      <= '0;
         min_row_ff      <= '0;
         max_row_ff      <= '0;
         seen_ff         <= 1'b0;
         frame_width_ff  <= CFG_DIM_W'(1);
         frame_height_ff <= CFG_DIM_W'(1);
         premul_on_ff    <= 1'b0;
         trim_on_ff      <= 1'b0;
         indexed_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         min_col_ff   <= min_col_in;
         max_col_ff   <= max_col_in;
         min_row_ff   <= min_row_in;
         max_row_ff   <= max_row_in;
         seen_ff      <= seen_in;
         if (csr_fire) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
               CSR_PREMULTIPLY:  premul_on_ff    <= csr_wdata[0];
               CSR_TRIM:         trim_on_ff      <= csr_wdata[0];
               CSR_INDEXED_MODE: indexed_ff      <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pixel_ff <= req_pixel_in;
      end
      if (s1_fire) begin
         rsp_pixel_ff  <= pixel_result;
         rsp_done_ff   <= rsp_done_in;
         rsp_left_ff   <= rsp_left_in;
         rsp_top_ff    <= rsp_top_in;
         rsp_width_ff  <= rsp_width_in;
         rsp_height_ff <= rsp_height_in;
         rsp_transp_ff <= rsp_transp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pixel_out       = rsp_pixel_ff;
   assign rsp_frame_done      = rsp_done_ff;
   assign rsp_box_left        = rsp_left_ff;
   assign rsp_box_top         = rsp_top_ff;
   assign rsp_box_width       = rsp_width_ff;
   assign rsp_box_height      = rsp_height_ff;
   assign rsp_all_transparent = rsp_transp_ff;

   // The last beat of a frame always reports a nonempty box.
   a_done_box_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> (rsp_width_ff != '0) && (rsp_height_ff != '0))
      else $error("frame end reported an empty box");

   // Beats inside a frame carry no box.
   a_mid_box_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_done_ff |-> (rsp_left_ff == '0) && (rsp_top_ff == '0) &&
         (rsp_width_ff == '0) && (rsp_height_ff == '0) && !rsp_transp_ff)
      else $error("box fields set before frame end");

   // An all-transparent frame reports the full frame from the origin.
   a_transparent_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_transp_ff |-> rsp_done_ff && (rsp_left_ff == '0) &&
         (rsp_top_ff == '0))
      else $error("transparent flag with a trimmed origin");

   // Once a visible pixel is seen the box corners stay ordered.
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (min_col_ff <= max_col_ff) && (min_row_ff <= max_row_ff))
      else $error("bounding box corners out of order");

endmodule

@@ rtl/aptb_pixel.sv @@
// ============================================================================
// aptb_pixel: per-pixel format conversion
// Premultiplies (if on) the three color bytes of an RGBA pixel by alpha, or
// reduces an indexed pixel to its index byte, and flags visible pixels.
// ============================================================================
module aptb_pixel
   import aptb_pkg::*;
(
   input  logic [PIXEL_W-1:0] pixel,
   input  mode_type           mode,
   output logic [PIXEL_W-1:0] pixel_result,
   output logic               visible
);

   logic [7:0]  alpha;
   logic [15:0] prod_r;
   logic [15:0] prod_g;
   logic [15:0] prod_b;

   assign alpha = pixel[31:24];

   // One 8x8 product per color byte.
   assign prod_r = 16'(pixel[7:0])   * 16'(alpha);
   assign prod_g = 16'(pixel[15:8])  * 16'(alpha);
   assign prod_b = 16'(pixel[23:16]) * 16'(alpha);

   // Select the output format and visibility rule.
   always_comb begin
      if (mode.indexed_mode) begin
         pixel_result = {24'd0, pixel[7:0]};
         visible      = (pixel[7:0] != 8'd0);
      end else begin
         if (mode.premultiply_on) begin
            pixel_result = {alpha, div255(prod_b), div255(prod_g), div255(prod_r)};
         end else begin
            pixel_result = pixel;
         end
         visible = (alpha != 8'd0);
      end
   end

endmodule

@@ tb/aptb_checker.sv @@
// ============================================================================
// aptb_checker: result predictor and comparator for the premultiply block
// Watches the pixel, result and register channels. It keeps its own copy of
// the registers and the position and box state, predicts one result beat per
// accepted pixel and compares every result beat field by field.
// ============================================================================
module aptb_checker
   import aptb_pkg::*;
#(
   parameter int MAX_DIMENSION = 4096
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_pixel_in,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [PIXEL_W-1:0]     rsp_pixel_out,
   input  logic                   rsp_frame_done,
   input  logic [BOX_POS_W-1:0]   rsp_box_left,
   input  logic [BOX_POS_W-1:0]   rsp_box_top,
   input  logic [BOX_SIZE_W-1:0]  rsp_box_width,
   input  logic [BOX_SIZE_W-1:0]  rsp_box_height,
   input  logic                   rsp_all_transparent,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   run_done,
   output int                     results_seen,
   output int                     error_count
);

   typedef struct packed {
      logic [PIXEL_W-1:0]    pixel;
      logic                  frame_done;
      logic [BOX_POS_W-1:0]  box_left;
      logic [BOX_POS_W-1:0]  box_top;
      logic [BOX_SIZE_W-1:0] box_width;
      logic [BOX_SIZE_W-1:0] box_height;
      logic                  all_transparent;
   } pixel_beat_type;

   localparam logic [CFG_DIM_W-1:0] DIM_CAP = CFG_DIM_W'(MAX_DIMENSION);

   // Register copy, starting from the reset values.
   logic [CFG_DIM_W-1:0] cfg_width = CFG_DIM_W'(1);
   logic [CFG_DIM_W-1:0] cfg_height = CFG_DIM_W'(1);
   logic                 cfg_premultiply = 1'b0;
   logic                 cfg_trim = 1'b0;
   logic                 cfg_indexed = 1'b0;

   // Raster position and the box of visible pixels in the current frame.
   logic [BOX_POS_W-1:0] col_pos = '0;
   logic [BOX_POS_W-1:0] row_pos = '0;
   logic [BOX_POS_W-1:0] min_col = '0;
   logic [BOX_POS_W-1:0] max_col = '0;
   logic [BOX_POS_W-1:0] min_row = '0;
   logic [BOX_POS_W-1:0] max_row = '0;
   logic                 box_found = 1'b0;

   pixel_beat_type expected_beats[$];
   int             mismatch_count = 0;
   logic           leftover_checked = 1'b0;

   assign error_count = mismatch_count;

   // A zero size counts as one and anything above the maximum is capped.
   function automatic logic [CFG_DIM_W-1:0] effective_dim(input logic [CFG_DIM_W-1:0] v);
      if (v == '0) return CFG_DIM_W'(1);
      if (v > DIM_CAP) return DIM_CAP;
      return v;
   endfunction

   // Exact floor(c * a / 255).
   function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] a);
      logic [15:0] prod;
      prod = {8'h00, c} * {8'h00, a};
      return 8'(prod / 16'd255);
   endfunction

   // Converts one pixel, updates position and box, and returns the result beat.
   function automatic pixel_beat_type premultiply_and_track(input logic [PIXEL_W-1:0] pix);
      pixel_beat_type       beat;
      logic [CFG_DIM_W-1:0] w;
      logic [CFG_DIM_W-1:0] h;
      logic [7:0]           a;
      logic                 visible;
      logic                 last;
      w = effective_dim(cfg_width);
      h = effective_dim(cfg_height);
      a = pix[31:24];
      beat = '0;

      if (cfg_indexed) begin
         beat.pixel = {24'h000000, pix[7:0]};
         visible = pix[7:0] != 8'h00;
      end else begin
         beat.pixel = pix;
         if (cfg_premultiply) begin
            beat.pixel = {a, scale_channel(pix[23:16], a), scale_channel(pix[15:8], a),
                          scale_channel(pix[7:0], a)};
         end
         visible = a != 8'h00;
      end

      // The box grows around every visible pixel while trim is on.
      if (cfg_trim && visible) begin
         if (!box_found) begin
            min_col = col_pos;
            max_col = col_pos;
            min_row = row_pos;
            max_row = row_pos;
            box_found = 1'b1;
         end else begin
            if (col_pos < min_col) min_col = col_pos;
            if (col_pos > max_col) max_col = col_pos;
            if (row_pos < min_row) min_row = row_pos;
            if (row_pos > max_row) max_row = row_pos;
         end
      end

      last = ({1'b0, col_pos} >= w - 13'd1) && ({1'b0, row_pos} >= h - 13'd1);
      beat.frame_done = last;

      // The last pixel carries the box and starts a new frame.
      if (last) begin
         if (cfg_trim && box_found) begin
            beat.box_left = min_col;
            beat.box_top = min_row;
            beat.box_width = {1'b0, max_col} - {1'b0, min_col} + 13'd1;
            beat.box_height = {1'b0, max_row} - {1'b0, min_row} + 13'd1;
         end else begin
            beat.box_width = w;
            beat.box_height = h;
            beat.all_transparent = cfg_trim;
         end
         col_pos = '0;
         row_pos = '0;
         box_found = 1'b0;
      end else if ({1'b0, col_pos} >= w - 13'd1) begin
         col_pos = '0;
         row_pos = row_pos + BOX_POS_W'(1);
      end else begin
         col_pos = col_pos + BOX_POS_W'(1);
      end
      return beat;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // All channels are sampled at the rising edge, before any update of that edge.
   always @(posedge clock) begin : watch_channels
      pixel_beat_type want;
      if (reset) begin
         cfg_width = CFG_DIM_W'(1);
         cfg_height = CFG_DIM_W'(1);
         cfg_premultiply = 1'b0;
         cfg_trim = 1'b0;
         cfg_indexed = 1'b0;
         col_pos = '0;
         row_pos = '0;
         min_col = '0;
         max_col = '0;
         min_row = '0;
         max_row = '0;
         box_found = 1'b0;
         expected_beats.delete();
         results_seen <= 0;
      end else begin
         // Register writes; indexes past the list are ignored.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  cfg_width = csr_wdata;
               CSR_FRAME_HEIGHT: cfg_height = csr_wdata;
               CSR_PREMULTIPLY:  cfg_premultiply = csr_wdata[0];
               CSR_TRIM:         cfg_trim = csr_wdata[0];
               CSR_INDEXED_MODE: cfg_indexed = csr_wdata[0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            expected_beats.push_back(premultiply_and_track(req_pixel_in));
         end

         // Each result beat is held against the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $error("result beat with no pixel outstanding: pixel_out %0h", rsp_pixel_out);
               mismatch_count++;
            end else begin
               want = expected_beats.pop_front();
               compare_field("pixel_out", want.pixel, rsp_pixel_out);
               compare_field("frame_done", 32'(want.frame_done), 32'(rsp_frame_done));
               compare_field("box_left", 32'(want.box_left), 32'(rsp_box_left));
               compare_field("box_top", 32'(want.box_top), 32'(rsp_box_top));
               compare_field("box_width", 32'(want.box_width), 32'(rsp_box_width));
               compare_field("box_height", 32'(want.box_height), 32'(rsp_box_height));
               compare_field("all_transparent", 32'(want.all_transparent),
                             32'(rsp_all_transparent));
            end
            results_seen <= results_seen + 1;
         end

         if (run_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_beats.size() != 0) begin
               $error("%0d result beats never arrived", expected_beats.size());
               mismatch_count++;
            end
         end
      end
   end

endmodule

@@ tb/tb_alpha_premultiply_trim_bounds.sv @@
// ============================================================================
// tb_alpha_premultiply_trim_bounds: stimulus and verdict for the trim block
// Drives directed frames (pixel extremes, empty frames, indexed pixels, size
// clamping and mid-frame resizing), then random frames with random gaps and
// result stalls. The checker predicts and compares each beat.
// ============================================================================
module tb_alpha_premultiply_trim_bounds;
   import aptb_pkg::*;

   localparam int MAX_DIM = 4096;
   localparam int RANDOM_ITEMS = 1870;
   localparam int IDLE_LIMIT = 2000;

   // Register indexes past the end of the register list.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]     rsp_pixel_out;
   logic                   rsp_frame_done;
   logic [BOX_POS_W-1:0]   rsp_box_left;
   logic [BOX_POS_W-1:0]   rsp_box_top;
   logic [BOX_SIZE_W-1:0]  rsp_box_width;
   logic [BOX_SIZE_W-1:0]  rsp_box_height;
   logic                   rsp_all_transparent;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   run_done = 1'b0;
   int                     results_seen;
   int                     error_count;

   int   pixels_sent = 0;
   int   gap_pct = 0;
   int   stall_pct = 0;
   int   stall_left = 0;
   int   idle_cycles = 0;
   logic gen_indexed = 1'b0;

   always #10 clock = ~clock;

   alpha_premultiply_trim_bounds #(.MAX_DIMENSION(MAX_DIM)) dut (.*);

   aptb_checker #(.MAX_DIMENSION(MAX_DIM)) pixel_check (.*);

   // Result stalls: mostly short, now and then long, no new ones when stall_pct is 0.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
         stall_left = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog on cycles in which no channel moves a beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_alpha_premultiply_trim_bounds: errors");
         $finish;
      end
   end

   function automatic int pick_gap();
      if (gap_pct == 0 || $urandom_range(99) >= gap_pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(10, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(2))
         0: return 0;
         1: return 15;
         default: return 50;
      endcase
   endfunction

   // Frame sizes: mostly tiny, sometimes zero, sometimes a few dozen.
   function automatic logic [CSR_DATA_W-1:0] pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 12) return CSR_DATA_W'($urandom_range(13, 40));
      return CSR_DATA_W'($urandom_range(1, 6));
   endfunction

   function automatic int effective_size(input logic [CSR_DATA_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   // Random pixel content; visibility sets alpha or the palette index.
   function automatic logic [PIXEL_W-1:0] make_pixel(input logic visible);
      logic [PIXEL_W-1:0] p;
      p = $urandom;
      case ($urandom_range(7))
         0: p[23:0] = 24'hFFFFFF;
         1: p[23:0] = 24'h000000;
         default: ;
      endcase
      if (gen_indexed) begin
         p[7:0] = visible ? 8'($urandom_range(1, 255)) : 8'h00;
      end else if (!visible) begin
         p[31:24] = 8'h00;
      end else begin
         p[31:24] = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
      end
      return p;
   endfunction

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_INDEXED_MODE) gen_indexed = value[0];
      @(posedge clock);
   endtask

   // One pixel beat; valid drops only across a gap, so back-to-back beats stay high.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   // Stops the pixel stream and waits until every result beat is back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_seen < pixels_sent) @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] dim_w;
      logic [CSR_DATA_W-1:0] dim_h;
      int                    area;
      int                    count;
      int                    vis_pct;
      int                    random_sent;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: 1x1 frames, trim off, full-frame box on every beat.
      gap_pct = 30;
      stall_pct = 30;
      send_pixel(32'hFFFFFFFF);
      send_pixel(32'h00000000);
      drain();

      // Premultiplied 3x2 frame with a trimmed box, then a fully transparent one.
      write_register(CSR_FRAME_WIDTH, 13'd3);
      write_register(CSR_FRAME_HEIGHT, 13'd2);
      write_register(CSR_PREMULTIPLY, 13'd1);
      write_register(CSR_TRIM, 13'd1);
      write_register(CSR_INDEXED_MODE, 13'd0);
      send_pixel(32'h00FFFFFF);
      send_pixel(32'h00000000);
      send_pixel(32'h01FFFFFF);
      send_pixel(32'h00123456);
      send_pixel(32'hFF123456);
      send_pixel(32'h80FF00FF);
      for (int i = 0; i < 6; i++) send_pixel(make_pixel(1'b0));
      drain();

      // Indexed pixels ignore the upper bits; index zero is transparent.
      write_register(CSR_INDEXED_MODE, 13'd1);
      write_register(CSR_FRAME_WIDTH, 13'd2);
      write_register(CSR_FRAME_HEIGHT, 13'd2);
      write_register(CSR_SPARE_FIRST, 13'h1FFF);
      send_pixel(32'hFFFFFF00);
      send_pixel(32'h000000FF);
      send_pixel(32'hABCDEF01);
      send_pixel(32'h12345600);
      drain();

      // Zero sizes count as one.
      write_register(CSR_INDEXED_MODE, 13'd0);
      write_register(CSR_TRIM, 13'd0);
      write_register(CSR_FRAME_WIDTH, 13'd0);
      write_register(CSR_FRAME_HEIGHT, 13'd0);
      send_pixel(32'h7F808080);
      send_pixel(32'hFF000000);
      drain();

      // Shrinking the width mid-row ends the row at the next pixel.
      write_register(CSR_FRAME_WIDTH, 13'd4);
      write_register(CSR_FRAME_HEIGHT, 13'd2);
      write_register(CSR_TRIM, 13'd1);
      for (int i = 0; i < 3; i++) send_pixel(make_pixel(1'b1));
      drain();
      write_register(CSR_FRAME_WIDTH, 13'd2);
      write_register(CSR_SPARE_LAST, 13'd0);
      for (int i = 0; i < 3; i++) send_pixel(make_pixel(i != 1));
      drain();

      // Random phases: whole frames, sometimes a partial one left for the next phase.
      dim_w = pick_dim();
      dim_h = pick_dim();
      write_register(CSR_FRAME_WIDTH, dim_w);
      write_register(CSR_FRAME_HEIGHT, dim_h);
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(9) < 7) begin
            dim_w = pick_dim();
            write_register(CSR_FRAME_WIDTH, dim_w);
         end
         if ($urandom_range(9) < 7) begin
            dim_h = pick_dim();
            write_register(CSR_FRAME_HEIGHT, dim_h);
         end
         if ($urandom_range(9) < 5) write_register(CSR_PREMULTIPLY, CSR_DATA_W'($urandom));
         if ($urandom_range(9) < 5) write_register(CSR_TRIM, CSR_DATA_W'($urandom));
         if ($urandom_range(9) < 3) write_register(CSR_INDEXED_MODE, CSR_DATA_W'($urandom));
         if ($urandom_range(19) == 0)
            write_register(CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                           CSR_DATA_W'($urandom));

         area = effective_size(dim_w) * effective_size(dim_h);
         count = area * ((area > 100) ? 1 : $urandom_range(1, 4));
         if (area > 1 && $urandom_range(3) == 0) count += $urandom_range(1, area - 1);
         if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
         case ($urandom_range(3))
            0: vis_pct = 0;
            1: vis_pct = 4;
            2: vis_pct = 50;
            default: vis_pct = 100;
         endcase
         gap_pct = pick_pct();
         stall_pct = pick_pct();

         for (int i = 0; i < count; i++) send_pixel(make_pixel($urandom_range(99) < vis_pct));
         random_sent += count;
         drain();
      end

      // Quiet tail so a stray result beat would still show up.
      stall_pct = 0;
      repeat (8) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (error_count == 0)
         $display("tb_alpha_premultiply_trim_bounds: clean");
      else
         $display("tb_alpha_premultiply_trim_bounds: errors");
      $finish;
   end

endmodule

@@ alpha_premultiply_trim_bounds.f @@
rtl/aptb_pkg.sv
rtl/aptb_pixel.sv
rtl/alpha_premultiply_trim_bounds.sv
tb/aptb_checker.sv
tb/tb_alpha_premultiply_trim_bounds.sv
